>>> rtl/lfcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcs_pkg
// Shared types and constants of the log-frequency correction summer.
// ----------------------------------------------------------------------------
package lfcs_pkg;

    // field widths
    localparam int MODE_W    = 2;
    localparam int SEL_W     = 3;
    localparam int FREQ_W    = 36;
    localparam int DB_W      = 16;
    localparam int OUT_W     = 20;
    localparam int ST_W      = 2;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 1;

    // log2 datapath: 6 bit exponent, Q0.16 fraction, 32 bit mantissa
    localparam int LOG_E_W = 6;
    localparam int LOG_F_W = 16;
    localparam int LOG_W   = LOG_E_W + LOG_F_W;
    localparam int MANT_W  = 32;
    localparam int LOG_STEPS = 16;

    // interpolation datapath
    localparam int DIFF_W = DB_W + 1;
    localparam int PROD_W = LOG_W + 1 + DIFF_W;
    localparam int DIVD_W = PROD_W;
    localparam int DIVS_W = LOG_W + 1;
    localparam int QUO_W  = DIFF_W;

    // defaults of the top level parameters
    localparam int NUM_TABLES_DEF = 8;
    localparam int MAX_POINTS_DEF = 64;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // mode codes on the input beat
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_ORDER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATE = 1'd1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_NONE
    } t_op;

    // classified item as it sits in the queue
    typedef struct packed {
        t_op                      op;
        logic                     sel_ok;
        logic [SEL_W-1:0]         tab;
        logic [FREQ_W-1:0]        freq;
        logic signed [DB_W-1:0]   pdb;
        logic signed [DB_W-1:0]   amp;
    } t_item;

    // configuration seen by the back end
    typedef struct packed {
        logic [MASK_W-1:0] enable;
        logic [MASK_W-1:0] negate;
    } t_cfg;

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQ
    } t_lphase;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dphase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEC,
        S_APP_CHK,
        S_APP_WR,
        S_Q_TAB,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SRCH,
        S_SRCH_CHK,
        S_USE_FIRST,
        S_GOT_LO,
        S_GOT_HI,
        S_LOG_HI,
        S_LOG_LO,
        S_LOG_F,
        S_MUL,
        S_DIVST,
        S_DIV,
        S_ACC,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

>>> rtl/log_freq_correction_summer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_freq_correction_summer
// Sums log-frequency interpolated correction tables and applies the total.
// ----------------------------------------------------------------------------
// Loads: a clear, a mode 3 beat or an append to a full table goes straight
// to the result; the first append to a table writes at once, and any other
// append first checks its order against the last point. A query visits every
// table in turn and skips a disabled or empty one. For each enabled non-empty
// table it takes the first point when the table has one point or the
// frequency is at or below the first point, the last point when it is at or
// above the last point, and otherwise runs a binary search for the bracket;
// unless the lower bracket frequency is zero that is followed by three log2
// passes (normalizing shifts, 16 squarings, then the result is handed back)
// and, unless the log span is zero, a multiply and a bit-serial divide. Items
// are worked one at a time through the shared log2 unit and divider. A
// two-entry queue takes new beats while the back end is busy, and a result
// register holds a finished beat until the output side takes it.
module log_freq_correction_summer import lfcs_pkg::*; #(
    parameter int NUM_TABLES = NUM_TABLES_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [MASK_W-1:0]       i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [MODE_W-1:0]       i_mode,
    input  wire logic [SEL_W-1:0]        i_table_select,
    input  wire logic [FREQ_W-1:0]       i_frequency_hz,
    input  wire logic signed [DB_W-1:0]  i_point_db,
    input  wire logic signed [DB_W-1:0]  i_amplitude_db,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_total_correction,
    output logic signed [OUT_W-1:0]      o_corrected_amplitude,
    output logic [ST_W-1:0]              o_status
);

    t_cfg  r_cfg;
    logic  w_head_valid;
    t_item w_head;
    logic  w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_cfg.enable <= i_cfg_data;
                CFG_NEGATE: r_cfg.negate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lfcs_front #(
        .NUM_TABLES (NUM_TABLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_table_select (i_table_select),
        .i_frequency_hz (i_frequency_hz),
        .i_point_db     (i_point_db),
        .i_amplitude_db (i_amplitude_db),
        .o_head_valid   (w_head_valid),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    lfcs_back #(
        .NUM_TABLES (NUM_TABLES),
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .i_head_valid          (w_head_valid),
        .i_head                (w_head),
        .o_pop                 (w_pop),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_total_correction    (o_total_correction),
        .o_corrected_amplitude (o_corrected_amplitude),
        .o_status              (o_status)
    );

endmodule
`default_nettype wire

>>> rtl/lfcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcs_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module lfcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/lfcs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcs_front
// Accepts input beats, classifies the mode and queues items for the back end.
// ----------------------------------------------------------------------------
module lfcs_front import lfcs_pkg::*; #(
    parameter int NUM_TABLES = NUM_TABLES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [MODE_W-1:0]      i_mode,
    input  wire logic [SEL_W-1:0]       i_table_select,
    input  wire logic [FREQ_W-1:0]      i_frequency_hz,
    input  wire logic signed [DB_W-1:0] i_point_db,
    input  wire logic signed [DB_W-1:0] i_amplitude_db,
    output logic                        o_head_valid,
    output t_item                       o_head,
    input  wire logic                   i_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_ent [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [FW-1:0]  r_fill;
    t_item          w_item;
    logic           w_push;

    // classify the incoming beat
    always_comb begin
        w_item.sel_ok = (int'(i_table_select) < NUM_TABLES);
        w_item.tab    = i_table_select;
        w_item.freq   = i_frequency_hz;
        w_item.pdb    = i_point_db;
        w_item.amp    = i_amplitude_db;
        unique case (i_mode)
            MODE_CLEAR:  w_item.op = OP_CLEAR;
            MODE_APPEND: w_item.op = OP_APPEND;
            MODE_QUERY:  w_item.op = OP_QUERY;
            default:     w_item.op = OP_NONE;
        endcase
    end

    assign o_stall      = (r_fill == FW'(QUEUE_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_ent[r_rp];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!w_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lfcs_log2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcs_log2
// Iterative log2: one bit of normalization per cycle, then sixteen squaring
// steps that each yield one fraction bit.
// ----------------------------------------------------------------------------
module lfcs_log2 import lfcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [FREQ_W-1:0] i_x,
    output logic                   o_done,
    output logic [LOG_W-1:0]       o_result
);

    localparam int KW = $clog2(LOG_STEPS);

    t_lphase              r_phase;
    t_lphase              n_phase;
    logic                 r_done;
    logic                 n_done;
    logic [FREQ_W-1:0]    r_x;
    logic [LOG_E_W-1:0]   r_e;
    logic [MANT_W-1:0]    r_m;
    logic [LOG_F_W-1:0]   r_frac;
    logic [KW-1:0]        r_k;
    logic [LOG_W-1:0]     r_result;
    logic [2*MANT_W-1:0]  w_sq;
    logic [MANT_W:0]      w_s;
    logic                 w_norm_end;

    // square shifted down by 31, bit 32 gives the next fraction bit
    assign w_sq       = r_m * r_m;
    assign w_s        = w_sq[2*MANT_W-1 -: MANT_W+1];
    assign w_norm_end = r_x[FREQ_W-1] || (r_e == '0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            L_IDLE: if (i_start) n_phase = L_NORM;
            L_NORM: if (w_norm_end) n_phase = L_SQ;
            L_SQ:   if (r_k == KW'(LOG_STEPS - 1)) n_phase = L_IDLE;
            default: n_phase = L_IDLE;
        endcase
        if (i_start) begin
            n_phase = L_NORM;
        end
    end

    // done pulse
    always_comb begin
        n_done = (r_phase == L_SQ) && (r_k == KW'(LOG_STEPS - 1)) && !i_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_e    <= LOG_E_W'(FREQ_W - 1);
            r_frac <= '0;
            r_k    <= '0;
        end else begin
            case (r_phase)
                L_NORM: begin
                    if (w_norm_end) begin
                        r_m <= r_x[FREQ_W-1 -: MANT_W];
                    end else begin
                        r_x <= {r_x[FREQ_W-2:0], 1'b0};
                        r_e <= r_e - 1'b1;
                    end
                end
                L_SQ: begin
                    r_k <= r_k + 1'b1;
                    if (w_s[MANT_W]) begin
                        r_m    <= w_s[MANT_W:1];
                        r_frac <= {r_frac[LOG_F_W-2:0], 1'b1};
                    end else begin
                        r_m    <= w_s[MANT_W-1:0];
                        r_frac <= {r_frac[LOG_F_W-2:0], 1'b0};
                    end
                    if (r_k == KW'(LOG_STEPS - 1)) begin
                        r_result <= {r_e, r_frac[LOG_F_W-2:0], w_s[MANT_W]};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> rtl/lfcs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfcs_div import lfcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DIVS_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIVD_W-1:0]      o_quotient
);

    localparam int CW = $clog2(DIVD_W);

    t_dphase            r_phase;
    t_dphase            n_phase;
    logic               r_done;
    logic               n_done;
    logic [DIVD_W-1:0]  r_q;
    logic [DIVS_W-1:0]  r_rem;
    logic [DIVS_W-1:0]  r_dvs;
    logic [CW-1:0]      r_cnt;
    logic [DIVS_W:0]    w_sh;
    logic               w_ge;
    logic               w_last;

    assign w_sh   = {r_rem, r_q[DIVD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_last = (r_cnt == CW'(DIVD_W - 1));

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            D_IDLE:  if (i_start) n_phase = D_RUN;
            D_RUN:   if (w_last) n_phase = D_IDLE;
            default: n_phase = D_IDLE;
        endcase
    end

    // done pulse
    always_comb begin
        n_done = (r_phase == D_RUN) && w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (r_phase == D_IDLE) begin
            if (i_start) begin
                r_q   <= i_dividend;
                r_dvs <= i_divisor;
                r_rem <= '0;
                r_cnt <= '0;
            end
        end else begin
            r_cnt <= r_cnt + 1'b1;
            r_q   <= {r_q[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? DIVS_W'(w_sh - {1'b0, r_dvs}) : w_sh[DIVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

>>> rtl/lfcs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcs_back
// Sequencer that loads table points and evaluates queries: clamp, binary
// search, log2 of three frequencies, multiply, divide and accumulate.
// ----------------------------------------------------------------------------
module lfcs_back import lfcs_pkg::*; #(
    parameter int NUM_TABLES = NUM_TABLES_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_head_valid,
    input  wire t_item                   i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_total_correction,
    output logic signed [OUT_W-1:0]      o_corrected_amplitude,
    output logic [ST_W-1:0]              o_status
);

    localparam int DEPTH = NUM_TABLES * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CTW   = $clog2(NUM_TABLES + 1);
    localparam int CW    = $clog2(MAX_POINTS + 1);

    t_state                    r_state;
    t_state                    n_state;
    t_item                     r_item;
    logic [CW-1:0]             r_cnt [NUM_TABLES];
    logic [CTW-1:0]            r_t;
    logic [CW-1:0]             r_lo;
    logic [CW-1:0]             r_hi;
    logic [CW-1:0]             r_mid;
    logic [FREQ_W-1:0]         r_flo;
    logic signed [DB_W-1:0]    r_vlo;
    logic signed [DB_W-1:0]    r_vhi;
    logic [LOG_W-1:0]          r_lhi;
    logic [LOG_W-1:0]          r_llo;
    logic [LOG_W-1:0]          r_num;
    logic [LOG_W-1:0]          r_span;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DB_W-1:0]    r_v;
    logic signed [OUT_W-1:0]   r_total;
    logic signed [OUT_W-1:0]   r_corr;
    logic [ST_W-1:0]           r_status;
    logic                      r_ov;
    logic signed [OUT_W-1:0]   r_o_total;
    logic signed [OUT_W-1:0]   r_o_corr;
    logic [ST_W-1:0]           r_o_status;

    logic [TW-1:0]             w_tab;
    logic [CW-1:0]             w_cnt;
    logic                      w_tab_used;
    logic [CW-1:0]             w_mid;
    logic [CW-1:0]             w_idx;
    logic [AW-1:0]             w_addr;
    logic                      w_we;
    logic [FREQ_W-1:0]         w_rd_freq;
    logic signed [DB_W-1:0]    w_rd_val;
    logic                      w_out_free;
    logic                      w_log_start;
    logic [FREQ_W-1:0]         w_log_x;
    logic                      w_log_done;
    logic [LOG_W-1:0]          w_log_res;
    logic                      w_div_start;
    logic [DIVD_W-1:0]         w_dividend;
    logic [DIVS_W-1:0]         w_divisor;
    logic                      w_div_done;
    logic [DIVD_W-1:0]         w_quo;
    logic signed [LOG_W:0]     w_span_s;
    logic signed [LOG_W:0]     w_numd;
    logic [LOG_W-1:0]          w_num;
    logic signed [DIFF_W-1:0]  w_dv;
    logic [PROD_W-1:0]         w_mag;
    logic signed [QUO_W:0]     w_q;
    logic signed [OUT_W-1:0]   w_vext;
    logic signed [DIFF_W:0]    w_vint;

    // current table and its fill
    assign w_tab      = (r_item.op == OP_QUERY) ? r_t[TW-1:0] : r_item.tab[TW-1:0];
    assign w_cnt      = r_cnt[w_tab];
    assign w_tab_used = i_cfg.enable[w_tab] && (w_cnt != '0);
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_addr     = AW'(w_tab) * AW'(MAX_POINTS) + AW'(w_idx);
    assign w_out_free = !r_ov || !i_stall;

    // interpolation arithmetic
    assign w_span_s   = $signed({1'b0, r_lhi}) - $signed({1'b0, r_llo});
    assign w_numd     = $signed({1'b0, w_log_res}) - $signed({1'b0, r_llo});
    assign w_num      = (w_numd < 0) ? '0 :
                        (w_numd > w_span_s) ? w_span_s[LOG_W-1:0] : w_numd[LOG_W-1:0];
    assign w_dv       = DIFF_W'(r_vhi) - DIFF_W'(r_vlo);
    assign w_mag      = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_dividend = {w_mag[DIVD_W-2:0], 1'b0} + DIVD_W'(r_span);
    assign w_divisor  = {r_span, 1'b0};
    assign w_q        = r_prod[PROD_W-1] ? -$signed({1'b0, w_quo[QUO_W-1:0]})
                                         : $signed({1'b0, w_quo[QUO_W-1:0]});
    assign w_vint     = (DIFF_W+1)'(r_vlo) + (DIFF_W+1)'(w_q);
    assign w_vext     = OUT_W'(r_v);

    // point memories
    lfcs_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (DEPTH)
    ) u_freq_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_item.freq),
        .o_rdata (w_rd_freq)
    );

    lfcs_ram #(
        .WIDTH (DB_W),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_item.pdb),
        .o_rdata (w_rd_val)
    );

    lfcs_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_log_start),
        .i_x      (w_log_x),
        .o_done   (w_log_done),
        .o_result (w_log_res)
    );

    lfcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_head_valid) n_state = S_DEC;
            S_DEC: begin
                unique case (r_item.op)
                    OP_APPEND: begin
                        if (!r_item.sel_ok || (w_cnt >= CW'(MAX_POINTS))) begin
                            n_state = S_OUT;
                        end else if (w_cnt == '0) begin
                            n_state = S_APP_WR;
                        end else begin
                            n_state = S_APP_CHK;
                        end
                    end
                    OP_QUERY: n_state = S_Q_TAB;
                    default:  n_state = S_OUT;
                endcase
            end
            S_APP_CHK: n_state = (r_item.freq < w_rd_freq) ? S_OUT : S_APP_WR;
            S_APP_WR:  n_state = S_OUT;
            S_Q_TAB: begin
                if (r_t == CTW'(NUM_TABLES)) begin
                    n_state = S_OUT;
                end else if (w_tab_used) begin
                    n_state = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST: begin
                if ((w_cnt == CW'(1)) || (r_item.freq <= w_rd_freq)) begin
                    n_state = S_ACC;
                end else begin
                    n_state = S_CHK_LAST;
                end
            end
            S_CHK_LAST: n_state = (r_item.freq >= w_rd_freq) ? S_ACC : S_SRCH;
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_SRCH_CHK;
                end else if ((r_lo == '0) || (r_lo >= w_cnt)) begin
                    n_state = S_USE_FIRST;
                end else begin
                    n_state = S_GOT_LO;
                end
            end
            S_SRCH_CHK:  n_state = S_SRCH;
            S_USE_FIRST: n_state = S_ACC;
            S_GOT_LO:    n_state = S_GOT_HI;
            S_GOT_HI:    n_state = (r_flo == '0) ? S_ACC : S_LOG_HI;
            S_LOG_HI:    if (w_log_done) n_state = S_LOG_LO;
            S_LOG_LO:    if (w_log_done) n_state = S_LOG_F;
            S_LOG_F: begin
                if (w_log_done) begin
                    n_state = (w_span_s <= 0) ? S_ACC : S_MUL;
                end
            end
            S_MUL:   n_state = S_DIVST;
            S_DIVST: n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_ACC;
            S_ACC:   n_state = S_Q_TAB;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_idx       = '0;
        w_log_start = 1'b0;
        w_log_x     = r_item.freq;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: o_pop = i_head_valid;
            S_DEC:  w_idx = w_cnt - 1'b1;
            S_APP_WR: begin
                w_idx = w_cnt;
                w_we  = 1'b1;
            end
            S_CHK_FIRST: w_idx = w_cnt - 1'b1;
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    w_idx = w_mid;
                end else if ((r_lo == '0) || (r_lo >= w_cnt)) begin
                    w_idx = '0;
                end else begin
                    w_idx = r_lo - 1'b1;
                end
            end
            S_GOT_LO: w_idx = r_lo;
            S_GOT_HI: begin
                w_log_start = (r_flo != '0);
                w_log_x     = w_rd_freq;
            end
            S_LOG_HI: begin
                w_log_start = w_log_done;
                w_log_x     = r_flo;
            end
            S_LOG_LO: w_log_start = w_log_done;
            S_DIVST:  w_div_start = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < NUM_TABLES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_DEC && r_item.op == OP_CLEAR && r_item.sel_ok) begin
                r_cnt[w_tab] <= '0;
            end
            if (r_state == S_APP_WR) begin
                r_cnt[w_tab] <= w_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    r_item <= i_head;
                end
            end
            S_DEC: begin
                r_total  <= '0;
                r_corr   <= '0;
                r_status <= ST_OK;
                r_t      <= '0;
                if (r_item.op == OP_APPEND && r_item.sel_ok &&
                    (w_cnt >= CW'(MAX_POINTS))) begin
                    r_status <= ST_FULL;
                end
            end
            S_APP_CHK: begin
                if (r_item.freq < w_rd_freq) begin
                    r_status <= ST_ORDER;
                end
            end
            S_Q_TAB: begin
                if (r_t == CTW'(NUM_TABLES)) begin
                    r_corr <= r_total + OUT_W'(r_item.amp);
                end else if (!w_tab_used) begin
                    r_t <= r_t + 1'b1;
                end
            end
            S_CHK_FIRST: r_v <= w_rd_val;
            S_CHK_LAST: begin
                r_v  <= w_rd_val;
                r_lo <= '0;
                r_hi <= w_cnt;
            end
            S_SRCH: r_mid <= w_mid;
            S_SRCH_CHK: begin
                if (w_rd_freq < r_item.freq) begin
                    r_lo <= r_mid + 1'b1;
                end else begin
                    r_hi <= r_mid;
                end
            end
            S_USE_FIRST: r_v <= w_rd_val;
            S_GOT_LO: begin
                r_flo <= w_rd_freq;
                r_vlo <= w_rd_val;
            end
            S_GOT_HI: begin
                r_vhi <= w_rd_val;
                r_v   <= r_vlo;
            end
            S_LOG_HI: if (w_log_done) r_lhi <= w_log_res;
            S_LOG_LO: if (w_log_done) r_llo <= w_log_res;
            S_LOG_F: begin
                if (w_log_done) begin
                    r_num  <= w_num;
                    r_span <= w_span_s[LOG_W-1:0];
                end
            end
            S_MUL: r_prod <= PROD_W'($signed({1'b0, r_num})) * PROD_W'(w_dv);
            S_DIV: if (w_div_done) r_v <= w_vint[DB_W-1:0];
            S_ACC: begin
                r_total <= i_cfg.negate[w_tab] ? r_total - w_vext : r_total + w_vext;
                r_t     <= r_t + 1'b1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_total  <= r_total;
                    r_o_corr   <= r_corr;
                    r_o_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_valid               = r_ov;
    assign o_total_correction    = r_o_total;
    assign o_corrected_amplitude = r_o_corr;
    assign o_status              = r_o_status;

endmodule
`default_nettype wire
